### rtl/hfua_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfua_pkg
// Shared types and constants for the H.264 RTP FU-A packetizer.
// ----------------------------------------------------------------------------
package hfua_pkg;

	// Configuration register indexes.
	localparam logic [1:0] CFG_MARKER_DEFAULT = 2'd0;
	localparam logic [1:0] CFG_START_SEQ      = 2'd1;
	localparam logic [1:0] CFG_START_TS       = 2'd2;
	localparam logic [1:0] CFG_TS_STEP        = 2'd3;

	localparam logic [31:0] TS_STEP_RESET = 32'd3600;

	// Header sizes in bytes.
	localparam int unsigned RTP_HDR_BYTES = 12;
	localparam int unsigned FU_HDR_BYTES  = 2;

	// NAL header masks and FU-A codes.
	localparam logic [7:0] NRI_MASK    = 8'he0;
	localparam logic [7:0] TYPE_MASK   = 8'h1f;
	localparam logic [7:0] FUA_TYPE    = 8'd28;
	localparam logic [7:0] FU_START    = 8'h80;
	localparam logic [7:0] FU_END      = 8'h40;

	// Largest fragment count index before the final fragment is forced.
	localparam logic [5:0] MAX_FRAG_IDX = 6'd63;

	typedef enum logic [0:0] {
		ST_IDLE,
		ST_EMIT
	} hfua_state_t;

	// Controller to datapath.
	typedef struct packed {
		logic load;
		logic emit;
	} hfua_cmd_t;

	// Datapath to controller.
	typedef struct packed {
		logic pkt_last;
	} hfua_status_t;

endpackage : hfua_pkg
`default_nettype wire

### rtl/hfua_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfua channel interfaces
// Valid/ready channels for NAL descriptors, packet descriptors and config.
// ----------------------------------------------------------------------------
interface hfua_nal_if;
	logic       valid;
	logic       ready;
	logic [7:0] nal_header;
	logic [15:0] nal_length;

	modport source (output valid, output nal_header, output nal_length, input ready);
	modport sink   (input valid, input nal_header, input nal_length, output ready);
endinterface : hfua_nal_if

interface hfua_pkt_if;
	logic        valid;
	logic        ready;
	logic [15:0] seq_number;
	logic [31:0] timestamp;
	logic        marker;
	logic        is_fragment;
	logic [7:0]  fua_ind;
	logic [7:0]  fua_hdr;
	logic [15:0] payload_offset;
	logic [13:0] payload_length;
	logic [13:0] packet_length;
	logic        last;

	modport source (
		output valid, output seq_number, output timestamp, output marker,
		output is_fragment, output fua_ind, output fua_hdr,
		output payload_offset, output payload_length, output packet_length,
		output last, input ready
	);
	modport sink (
		input valid, input seq_number, input timestamp, input marker,
		input is_fragment, input fua_ind, input fua_hdr,
		input payload_offset, input payload_length, input packet_length,
		input last, output ready
	);
endinterface : hfua_pkt_if

interface hfua_cfg_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [31:0] data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface : hfua_cfg_if
`default_nettype wire

### rtl/h264_rtp_fua_packetizer_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_unit
// RTP packet descriptors (single NAL or FU-A fragments) for H.264 NAL units.
// ----------------------------------------------------------------------------
// One beat on nal_in describes a NAL unit by its header byte and its length.
// The block answers with one or more packet descriptor beats on pkt_out, in
// order, the last one flagged by last. A NAL of at most PACKET_BYTES-12 bytes
// becomes one single-NAL packet with the marker set; a longer one loses its
// header byte and is cut into FU-A fragments of PACKET_BYTES-14 payload bytes,
// the final fragment carrying the rest and the marker, the others carrying
// marker_default. Every packet takes the running sequence number, which then
// steps by one; all packets of a NAL share the running timestamp, which steps
// by ts_step after the NAL. A NAL is taken in while the block is idle; its
// packets (1 to 64 of them) are then issued in turn by the controller's emit
// sequencer into the single packet output register, one packet per free
// slot. The next NAL is taken while the final packet still waits on
// pkt_out. Configuration writes on cfg are always accepted and are to be
// issued only while the block is idle; a write to start_seq or start_ts loads
// the sequence or timestamp counter directly.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_unit #(
	parameter int unsigned PACKET_BYTES = 1400
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	hfua_nal_if.sink   nal_in,
	hfua_pkt_if.source pkt_out,
	hfua_cfg_if.sink   cfg
);
	import hfua_pkg::*;

	hfua_cmd_t    cmd;
	hfua_status_t status;

	// The config channel never stalls.
	assign cfg.ready = 1'b1;

	hfua_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (nal_in.valid),
		.in_ready  (nal_in.ready),
		.out_valid (pkt_out.valid),
		.out_ready (pkt_out.ready),
		.cmd       (cmd),
		.status    (status)
	);

	hfua_datapath #(
		.PACKET_BYTES (PACKET_BYTES)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.nal_header     (nal_in.nal_header),
		.nal_length     (nal_in.nal_length),
		.cfg_we         (cfg.valid),
		.cfg_index      (cfg.index),
		.cfg_data       (cfg.data),
		.seq_number     (pkt_out.seq_number),
		.timestamp      (pkt_out.timestamp),
		.marker         (pkt_out.marker),
		.is_fragment    (pkt_out.is_fragment),
		.fua_ind        (pkt_out.fua_ind),
		.fua_hdr        (pkt_out.fua_hdr),
		.payload_offset (pkt_out.payload_offset),
		.payload_length (pkt_out.payload_length),
		.packet_length  (pkt_out.packet_length),
		.last           (pkt_out.last)
	);

endmodule : h264_rtp_fua_packetizer_unit
`default_nettype wire

### rtl/hfua_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfua_ctrl
// Sequencer: takes one NAL descriptor, then issues one packet per free slot.
// ----------------------------------------------------------------------------
module hfua_ctrl (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output hfua_pkg::hfua_cmd_t        cmd,
	input  wire hfua_pkg::hfua_status_t status
);
	import hfua_pkg::*;

	hfua_state_t state_q, state_d;
	logic        out_valid_q;
	logic        slot_free;

	assign slot_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) state_d = ST_EMIT;
			end
			ST_EMIT: begin
				if (slot_free && status.pkt_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		in_ready = 1'b0;
		cmd.load = 1'b0;
		cmd.emit = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				cmd.load = in_valid;
			end
			ST_EMIT: begin
				cmd.emit = slot_free;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;

endmodule : hfua_ctrl
`default_nettype wire

### rtl/hfua_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfua_datapath
// Counters, config registers, fragment state and the packet output register.
// ----------------------------------------------------------------------------
module hfua_datapath #(
	parameter int unsigned PACKET_BYTES = 1400
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire hfua_pkg::hfua_cmd_t    cmd,
	output hfua_pkg::hfua_status_t      status,
	input  wire logic [7:0]             nal_header,
	input  wire logic [15:0]            nal_length,
	input  wire logic                   cfg_we,
	input  wire logic [1:0]             cfg_index,
	input  wire logic [31:0]            cfg_data,
	output logic [15:0]                 seq_number,
	output logic [31:0]                 timestamp,
	output logic                        marker,
	output logic                        is_fragment,
	output logic [7:0]                  fua_ind,
	output logic [7:0]                  fua_hdr,
	output logic [15:0]                 payload_offset,
	output logic [13:0]                 payload_length,
	output logic [13:0]                 packet_length,
	output logic                        last
);
	import hfua_pkg::*;

	localparam logic [15:0] SINGLE_MAX = 16'(PACKET_BYTES - RTP_HDR_BYTES);
	localparam logic [13:0] FRAG       = 14'(PACKET_BYTES - RTP_HDR_BYTES - FU_HDR_BYTES);
	localparam logic [13:0] PKT_FULL   = 14'(PACKET_BYTES);
	localparam logic [13:0] RTP_LEN    = 14'(RTP_HDR_BYTES);
	localparam logic [13:0] FUA_LEN    = 14'(RTP_HDR_BYTES + FU_HDR_BYTES);

	logic        marker_default_q;
	logic [31:0] ts_step_q;
	logic [15:0] next_seq_q;
	logic [31:0] next_ts_q;

	logic [7:0]  hdr_q;
	logic        single_q;
	logic [15:0] rest_q;
	logic [15:0] off_q;
	logic [5:0]  cnt_q;
	logic        first_q;

	logic        more_frag;
	logic        frag_last;
	logic        pkt_last;
	logic [7:0]  indicator;
	logic [7:0]  nal_type;

	assign more_frag = (rest_q > {2'b00, FRAG}) && (cnt_q != MAX_FRAG_IDX);
	assign frag_last = !first_q && !more_frag;
	assign pkt_last  = single_q || frag_last;
	assign indicator = (hdr_q & NRI_MASK) | FUA_TYPE;
	assign nal_type  = hdr_q & TYPE_MASK;
	assign status.pkt_last = pkt_last;

	// Counters, config regs. User writes must come only while idle; unchecked.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			marker_default_q <= 1'b0;
			ts_step_q        <= TS_STEP_RESET;
			next_seq_q       <= '0;
			next_ts_q        <= '0;
		end else begin
			if (cmd.emit) begin
				next_seq_q <= next_seq_q + 16'd1;
				if (pkt_last) next_ts_q <= next_ts_q + ts_step_q;
			end else if (cfg_we) begin
				unique case (cfg_index)
					CFG_MARKER_DEFAULT: marker_default_q <= cfg_data[0];
					CFG_START_SEQ:      next_seq_q       <= cfg_data[15:0];
					CFG_START_TS:       next_ts_q        <= cfg_data;
					CFG_TS_STEP:        ts_step_q        <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	// Per-NAL fragment state.
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			hdr_q    <= nal_header;
			single_q <= (nal_length <= SINGLE_MAX);
			rest_q   <= (nal_length <= SINGLE_MAX) ? nal_length : nal_length - 16'd1;
			off_q    <= 16'd1;
			cnt_q    <= '0;
			first_q  <= 1'b1;
		end else if (cmd.emit) begin
			rest_q  <= rest_q - {2'b00, FRAG};
			off_q   <= off_q + {2'b00, FRAG};
			cnt_q   <= cnt_q + 6'd1;
			first_q <= 1'b0;
		end
	end

	// Packet descriptor output register.
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			seq_number <= next_seq_q;
			timestamp  <= next_ts_q;
			if (single_q) begin
				marker         <= 1'b1;
				is_fragment    <= 1'b0;
				fua_ind        <= '0;
				fua_hdr        <= '0;
				payload_offset <= '0;
				payload_length <= rest_q[13:0];
				packet_length  <= rest_q[13:0] + RTP_LEN;
				last           <= 1'b1;
			end else if (frag_last) begin
				marker         <= 1'b1;
				is_fragment    <= 1'b1;
				fua_ind        <= indicator;
				fua_hdr        <= nal_type | FU_END;
				payload_offset <= off_q;
				payload_length <= rest_q[13:0];
				packet_length  <= rest_q[13:0] + FUA_LEN;
				last           <= 1'b1;
			end else begin
				marker         <= marker_default_q;
				is_fragment    <= 1'b1;
				fua_ind        <= indicator;
				fua_hdr        <= first_q ? (nal_type | FU_START) : nal_type;
				payload_offset <= off_q;
				payload_length <= FRAG;
				packet_length  <= PKT_FULL;
				last           <= 1'b0;
			end
		end
	end

endmodule : hfua_datapath
`default_nettype wire

### rtl/hfua_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// hfua_checker
// Port-level assertions for the packetizer, bound to the top level.
// ----------------------------------------------------------------------------
module hfua_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_valid,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] seq_number,
	input wire logic        marker,
	input wire logic        is_fragment,
	input wire logic [7:0]  fua_ind,
	input wire logic [7:0]  fua_hdr,
	input wire logic [15:0] payload_offset,
	input wire logic [13:0] payload_length,
	input wire logic [13:0] packet_length,
	input wire logic        last
);
	import hfua_pkg::*;

	// A stalled beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(seq_number)
			&& $stable(payload_length) && $stable(last))
		else $error("pkt_out beat changed while stalled");

	// A NAL in work blocks the next one.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready)
		else $error("nal_in accepted while a NAL is in work");

	// Single packets carry no FU bytes and close their NAL.
	a_single: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !is_fragment |-> last && marker && fua_ind == 8'd0
			&& fua_hdr == 8'd0 && payload_offset == 16'd0
			&& packet_length == payload_length + 14'(RTP_HDR_BYTES))
		else $error("malformed single packet descriptor");

	// Fragments carry FU-A type and an end bit that matches last.
	a_frag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && is_fragment |-> fua_ind[4:0] == FUA_TYPE[4:0]
			&& fua_hdr[6] == last && !(fua_hdr[7] && fua_hdr[6])
			&& packet_length == payload_length + 14'(RTP_HDR_BYTES + FU_HDR_BYTES))
		else $error("malformed FU-A fragment descriptor");

endmodule : hfua_checker

bind h264_rtp_fua_packetizer_unit hfua_checker u_hfua_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.in_valid       (nal_in.valid),
	.in_ready       (nal_in.ready),
	.out_valid      (pkt_out.valid),
	.out_ready      (pkt_out.ready),
	.seq_number     (pkt_out.seq_number),
	.marker         (pkt_out.marker),
	.is_fragment    (pkt_out.is_fragment),
	.fua_ind        (pkt_out.fua_ind),
	.fua_hdr        (pkt_out.fua_hdr),
	.payload_offset (pkt_out.payload_offset),
	.payload_length (pkt_out.payload_length),
	.packet_length  (pkt_out.packet_length),
	.last           (pkt_out.last)
);
`default_nettype wire

### test/h264_rtp_fua_packetizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// h264_rtp_fua_packetizer_unit_tb
// Self-checking bench for the H.264 RTP FU-A packetizer: NAL descriptors go in
// on a valid/ready channel, and every packet descriptor beat that comes out is
// compared field by field with a packetizer predictor kept in the bench.
// ----------------------------------------------------------------------------
module h264_rtp_fua_packetizer_unit_tb;
	import hfua_pkg::*;

	localparam int unsigned PACKET_BYTES      = 1400;
	localparam int unsigned SINGLE_MAX_BYTES  = PACKET_BYTES - RTP_HDR_BYTES;
	localparam int unsigned FRAG_BYTES        = SINGLE_MAX_BYTES - FU_HDR_BYTES;
	localparam int unsigned LONG_STALL_CYCLES = 300;
	localparam int unsigned SETTLE_CYCLES     = 8;

	// One packet descriptor, laid out as the output channel carries it.
	typedef struct packed {
		logic [15:0] seq_number;
		logic [31:0] timestamp;
		logic        marker;
		logic        is_fragment;
		logic [7:0]  fua_ind;
		logic [7:0]  fua_hdr;
		logic [15:0] payload_offset;
		logic [13:0] payload_length;
		logic [13:0] packet_length;
		logic        last;
	} pkt_desc_t;

	logic clk = 1'b0;
	logic arst_n;

	hfua_nal_if nal_if ();
	hfua_pkt_if pkt_if ();
	hfua_cfg_if cfg_if ();

	h264_rtp_fua_packetizer_unit #(
		.PACKET_BYTES(PACKET_BYTES)
	) DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.nal_in (nal_if),
		.pkt_out(pkt_if),
		.cfg    (cfg_if)
	);

	always #1 clk = ~clk;

	// Predictor copy of the block's registers and counters. The start
	// registers only matter through the counters they load, so the bench keeps
	// the counters alone.
	logic        pred_marker_default;
	logic [31:0] pred_ts_step;
	logic [15:0] pred_seq;
	logic [31:0] pred_ts;

	// Packet descriptors predicted but not yet seen on the output, oldest first.
	pkt_desc_t pending_pkts[$];

	int  mismatch_cnt = 0;
	bit  idle_en = 1'b1;
	bit  long_stall_req = 1'b0;

	// Appends one predicted packet; every packet consumes a sequence number.
	function automatic void push_packet(input logic mark, input logic frag,
			input logic [7:0] ind, input logic [7:0] fuh, input int unsigned off,
			input int unsigned plen, input int unsigned pkt_len, input logic lst);
		pkt_desc_t d;
		d.seq_number     = pred_seq;
		d.timestamp      = pred_ts;
		d.marker         = mark;
		d.is_fragment    = frag;
		d.fua_ind        = ind;
		d.fua_hdr        = fuh;
		d.payload_offset = off[15:0];
		d.payload_length = plen[13:0];
		d.packet_length  = pkt_len[13:0];
		d.last           = lst;
		pending_pkts.push_back(d);
		pred_seq = pred_seq + 16'd1;
	endfunction

	// Works out every packet that one NAL unit turns into. A NAL that fits
	// goes out whole with the marker set. A longer one drops its header byte,
	// and the rest is cut into full fragments, the final fragment taking the
	// remainder, the end bit and the marker. The timestamp steps once per NAL.
	function automatic void packetize_nal(input logic [7:0] hdr, input logic [15:0] len);
		int unsigned rest;
		int unsigned off;
		int unsigned n;
		logic [7:0]  ind;
		logic [7:0]  nal_type;
		logic [7:0]  fuh;
		if (len <= SINGLE_MAX_BYTES) begin
			push_packet(1'b1, 1'b0, 8'h00, 8'h00, 0, 32'(len), 32'(len) + RTP_HDR_BYTES,
				1'b1);
		end else begin
			ind      = (hdr & NRI_MASK) | FUA_TYPE;
			nal_type = hdr & TYPE_MASK;
			rest     = 32'(len) - 1;
			off      = 1;
			fuh      = nal_type | FU_START;
			n        = 0;
			do begin
				push_packet(pred_marker_default, 1'b1, ind, fuh, off, FRAG_BYTES,
					PACKET_BYTES, 1'b0);
				n++;
				off  += FRAG_BYTES;
				rest -= FRAG_BYTES;
				fuh   = nal_type;
			end while (rest > FRAG_BYTES && n < MAX_FRAG_IDX);
			push_packet(1'b1, 1'b1, ind, nal_type | FU_END, off, rest,
				rest + RTP_HDR_BYTES + FU_HDR_BYTES, 1'b1);
		end
		pred_ts = pred_ts + pred_ts_step;
	endfunction

	// Offers one NAL descriptor beat and returns at the edge that takes it.
	// The valid is left high so that a following beat can go out back to
	// back; a random gap first drops valid for a burst of cycles.
	task automatic send_nal(input logic [7:0] hdr, input logic [15:0] len);
		if (idle_en && $urandom_range(0, 3) == 0) begin
			nal_if.valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
		nal_if.valid      <= 1'b1;
		nal_if.nal_header <= hdr;
		nal_if.nal_length <= len;
		do @(posedge clk); while (!nal_if.ready);
		packetize_nal(hdr, len);
	endtask

	// Lengths lean toward single packets and short fragment runs, with the
	// size boundaries and the full 16-bit range mixed in.
	function automatic logic [15:0] rand_nal_length();
		case ($urandom_range(0, 9)) inside
			[0:4]: rand_nal_length = 16'($urandom_range(0, SINGLE_MAX_BYTES));
			[5:7]: rand_nal_length = 16'($urandom_range(SINGLE_MAX_BYTES + 1, 8000));
			8: begin
				case ($urandom_range(0, 3))
					0: rand_nal_length = 16'(SINGLE_MAX_BYTES);
					1: rand_nal_length = 16'(SINGLE_MAX_BYTES + 1);
					2: rand_nal_length = 16'(2 * FRAG_BYTES + 1);
					default: rand_nal_length = 16'hffff;
				endcase
			end
			default: rand_nal_length = 16'($urandom_range(0, 65535));
		endcase
	endfunction

	task automatic send_random_nals(input int count);
		for (int i = 0; i < count; i++) begin
			send_nal(8'($urandom_range(0, 255)), rand_nal_length());
		end
	endtask

	// Drops the NAL valid and waits until every predicted packet has come out.
	// Every NAL yields at least one packet, so once the store is empty the
	// block is idle again; a settle wait is added all the same.
	task automatic wait_drained();
		nal_if.valid <= 1'b0;
		while (pending_pkts.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// One configuration beat; the predictor takes the write at the same edge.
	task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
		cfg_if.valid <= 1'b1;
		cfg_if.index <= idx;
		cfg_if.data  <= val;
		do @(posedge clk); while (!cfg_if.ready);
		case (idx)
			CFG_MARKER_DEFAULT: pred_marker_default = val[0];
			CFG_START_SEQ:      pred_seq            = val[15:0];
			CFG_START_TS:       pred_ts             = val;
			CFG_TS_STEP:        pred_ts_step        = val;
			default: ;
		endcase
		cfg_if.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_field(input string name, input longint unsigned want,
			input longint unsigned got);
		if (want != got) begin
			mismatch_cnt++;
			$display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
		end
	endtask

	// Packet checker: every beat taken on the output is matched against the
	// oldest prediction. Sampling at the edge sees the values that the edge
	// takes, since the block and the bench both update after it.
	always @(posedge clk) begin : pkt_check
		pkt_desc_t want;
		if (arst_n && pkt_if.valid && pkt_if.ready) begin
			if (pending_pkts.size() == 0) begin
				mismatch_cnt++;
				$display("%0t: unexpected packet beat: expected none, actual seq 0x%0h",
					$time, pkt_if.seq_number);
			end else begin
				want = pending_pkts.pop_front();
				check_field("seq_number",     want.seq_number,     pkt_if.seq_number);
				check_field("timestamp",      want.timestamp,      pkt_if.timestamp);
				check_field("marker",         want.marker,         pkt_if.marker);
				check_field("is_fragment",    want.is_fragment,    pkt_if.is_fragment);
				check_field("fua_ind",        want.fua_ind,        pkt_if.fua_ind);
				check_field("fua_hdr",        want.fua_hdr,        pkt_if.fua_hdr);
				check_field("payload_offset", want.payload_offset, pkt_if.payload_offset);
				check_field("payload_length", want.payload_length, pkt_if.payload_length);
				check_field("packet_length",  want.packet_length,  pkt_if.packet_length);
				check_field("last",           want.last,           pkt_if.last);
			end
		end
	end

	// Output ready driver. It normally takes every beat, drops ready for
	// random bursts while idling is enabled, and on request holds it low for
	// a long counted stretch so that the block backs up into its input.
	initial begin : pkt_ready_drv
		int unsigned n;
		pkt_if.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (long_stall_req) begin
				pkt_if.ready <= 1'b0;
				repeat (LONG_STALL_CYCLES) @(posedge clk);
				long_stall_req = 1'b0;
			end else if (idle_en && $urandom_range(0, 4) == 0) begin
				n = $urandom_range(1, 6);
				pkt_if.ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				pkt_if.ready <= 1'b1;
			end
		end
	end

	// Straight after reset, with the register defaults: sequence from zero,
	// timestamp from zero, step of 3600, fragments without marker.
	task automatic test_reset_defaults();
		send_nal(8'h67, 16'd20);
		send_nal(8'h65, 16'd3000);
		send_nal(8'h41, 16'd1388);
		wait_drained();
	endtask

	// Size boundaries and header extremes. The counters start just below
	// their wrap points and the step is the largest, so both counters wrap.
	// A zero length still gives one single packet of header bytes only.
	task automatic test_size_boundaries();
		write_reg(CFG_MARKER_DEFAULT, 32'd1);
		write_reg(CFG_START_SEQ, 32'h0000_fffd);
		write_reg(CFG_START_TS, 32'hffff_fff0);
		write_reg(CFG_TS_STEP, 32'hffff_ffff);
		send_nal(8'h00, 16'd0);
		send_nal(8'hff, 16'd1);
		send_nal(8'h1f, 16'(SINGLE_MAX_BYTES - 1));
		send_nal(8'he0, 16'(SINGLE_MAX_BYTES));
		send_nal(8'h7c, 16'(SINGLE_MAX_BYTES + 1));
		send_nal(8'h65, 16'(2 * FRAG_BYTES));
		send_nal(8'h80, 16'(2 * FRAG_BYTES + 1));
		send_nal(8'h9f, 16'(2 * FRAG_BYTES + 2));
		send_nal(8'hff, 16'hffff);
		send_nal(8'h00, 16'hffff);
		send_nal(8'h5a, 16'h8000);
		wait_drained();
	endtask

	// The output is held off for a long stretch while NAL beats keep being
	// offered, so the block fills up and must stall its input.
	task automatic test_output_backpressure();
		long_stall_req = 1'b1;
		send_random_nals(8);
		wait_drained();
	endtask

	// The sender stops until every packet has come out, then resumes.
	task automatic test_sender_pause();
		send_random_nals(3);
		wait_drained();
		send_random_nals(3);
		wait_drained();
	endtask

	// Random NAL streams over several register settings, the extremes among
	// them. Upper data bits of the narrow registers are filled with noise.
	task automatic test_random_phases();
		logic [31:0] seq_val;
		logic [31:0] ts_val;
		logic [31:0] step_val;
		for (int p = 0; p < 5; p++) begin
			case (p)
				0:       seq_val = 32'h0000_0000;
				1:       seq_val = 32'h0000_ffff;
				default: seq_val = $urandom;
			endcase
			ts_val   = (p == 2) ? 32'hffff_ffff : ((p == 0) ? 32'd0 : $urandom);
			step_val = (p == 3) ? 32'd0 : ((p == 4) ? 32'hffff_ffff : $urandom);
			write_reg(CFG_MARKER_DEFAULT, ($urandom & ~32'd1) | (p % 2));
			write_reg(CFG_START_SEQ, seq_val);
			write_reg(CFG_START_TS, ts_val);
			write_reg(CFG_TS_STEP, step_val);
			send_random_nals(16);
			wait_drained();
		end
	endtask

	// Final stretch with both sides running flat out.
	task automatic test_full_rate();
		idle_en = 1'b0;
		write_reg(CFG_MARKER_DEFAULT, 32'd1);
		write_reg(CFG_TS_STEP, 32'd3600);
		send_random_nals(20);
		wait_drained();
	endtask

	// Main sequence: reset once, then the tests in turn, then the verdict.
	initial begin : main_seq
		arst_n            = 1'b0;
		nal_if.valid      = 1'b0;
		nal_if.nal_header = 8'h00;
		nal_if.nal_length = 16'h0000;
		cfg_if.valid      = 1'b0;
		cfg_if.index      = CFG_MARKER_DEFAULT;
		cfg_if.data       = 32'h0;

		pred_marker_default = 1'b0;
		pred_ts_step        = TS_STEP_RESET;
		pred_seq            = 16'h0000;
		pred_ts             = 32'h0;

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		test_reset_defaults();
		test_size_boundaries();
		test_output_backpressure();
		test_sender_pause();
		test_random_phases();
		test_full_rate();

		repeat (SETTLE_CYCLES) @(posedge clk);
		if (mismatch_cnt == 0 && pending_pkts.size() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	// Watchdog far beyond the slowest correct run.
	initial begin : watchdog
		#1000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule : h264_rtp_fua_packetizer_unit_tb
